// File: sv/volume_axis_projection_top_assert.svh
// Assertion macros shared by the axis projection RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef VOLUME_AXIS_PROJECTION_TOP_ASSERT_SVH
`define VOLUME_AXIS_PROJECTION_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define VAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define VAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/vap_pkg.sv
// Shared types and fixed constants of the axis projection block.
// No dependencies.
package vap_pkg;

	localparam int SZW       = 7;  // configured size width
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 7;
	localparam int RES_W     = 40;
	localparam int POS_W     = 6;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd4;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [1:0] OP_MAX = 2'd0;
	localparam logic [1:0] OP_MIN = 2'd1;
	localparam logic [1:0] OP_SUM = 2'd2;
	localparam logic [1:0] OP_AVG = 2'd3;

	typedef struct packed {
		logic accept;     // latch item, read accumulator entry
		logic upd;        // write back entry, advance position
		logic div_start;
		logic div_take;   // capture quotient
		logic load_pick;  // load output from fresh reduction
		logic load_res;   // load output from held result
	} cmd_t;

	typedef struct packed {
		logic active;
		logic last;
		logic avg;
		logic div_busy;
	} sts_t;

endpackage

// File: sv/vap_ifs.sv
// Channel interfaces of the axis projection block: voxel, result, config.
// Depends on vap_pkg.
interface vap_in_if #(parameter int VALUE_BITS = 32);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] voxel_value;
	logic                         include_flag;
	modport source (output valid, voxel_value, include_flag, input ready);
	modport sink (input valid, voxel_value, include_flag, output ready);
endinterface

interface vap_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [vap_pkg::RES_W-1:0] result_value;
	logic [vap_pkg::POS_W-1:0]       out_pos_a;
	logic [vap_pkg::POS_W-1:0]       out_pos_b;
	logic                            volume_done;
	modport source (output valid, result_value, out_pos_a, out_pos_b, volume_done,
		input ready);
	modport sink (input valid, result_value, out_pos_a, out_pos_b, volume_done,
		output ready);
endinterface

interface vap_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [vap_pkg::CFG_IDX_W-1:0]     index;
	logic [vap_pkg::CFG_DAT_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/vap_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend by unsigned divisor.
// Depends on vap_pkg.
module vap_div #(
	parameter int TOT_W = 38
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [TOT_W-1:0]    dividend,
	input  logic [vap_pkg::SZW-1:0]    divisor,
	output logic                       busy,
	output logic signed [TOT_W-1:0]    quotient
);
	localparam int CW = $clog2(TOT_W + 1);

	logic [CW-1:0]             cnt_q;
	logic [TOT_W-1:0]          mag_q;
	logic [vap_pkg::SZW-1:0]   rem_q;
	logic [vap_pkg::SZW-1:0]   den_q;
	logic                      neg_q;
	logic [vap_pkg::SZW:0]     rem2;
	logic                      ge;

	assign rem2 = {rem_q, mag_q[TOT_W-1]};
	assign ge   = rem2 >= {1'b0, den_q};
	assign busy = cnt_q != '0;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(TOT_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[TOT_W-1];
			mag_q <= dividend[TOT_W-1] ? -dividend : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy) begin
			rem_q <= ge ? vap_pkg::SZW'(rem2 - {1'b0, den_q}) : rem2[vap_pkg::SZW-1:0];
			mag_q <= {mag_q[TOT_W-2:0], ge};
		end
	end
endmodule

// File: sv/vap_ctrl.sv
// Sequencer of the axis projection block: accept, update, divide, emit.
// Depends on vap_pkg and the assertion macro header.
`include "volume_axis_projection_top_assert.svh"
module vap_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  vap_pkg::sts_t sts,
	output vap_pkg::cmd_t cmd
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_UPD  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = state_q == S_IDLE;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd   = 1'b1;
				state_nxt = S_IDLE;
				if (sts.active && sts.last) begin
					if (sts.avg) begin
						cmd.div_start = 1'b1;
						state_nxt     = S_DIV;
					end else if (out_free) begin
						cmd.load_pick = 1'b1;
					end else begin
						state_nxt = S_EMIT;
					end
				end
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					cmd.div_take = 1'b1;
					state_nxt    = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.load_res = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_pick || cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`VAP_ASSERT_NEXT(a_accept_upd, clk, arst_n, cmd.accept, state_q == S_UPD, "accept not followed by update")
	`VAP_ASSERT_NOW(a_load_free, clk, arst_n, cmd.load_pick || cmd.load_res, out_free, "output overwritten while stalled")
	`VAP_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_pick || cmd.load_res, out_valid_q, "loaded result not presented")
	`VAP_ASSERT_NEXT(a_div_wait, clk, arst_n, cmd.div_start, state_q == S_DIV && sts.div_busy, "divider did not start")
endmodule

// File: sv/vap_dp.sv
// Datapath: config registers, raster position, accumulator memory, result register.
// Depends on vap_pkg and vap_div.
module vap_dp #(
	parameter int MAX_X      = 64,
	parameter int MAX_Y      = 64,
	parameter int MAX_Z      = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [vap_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vap_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic signed [VALUE_BITS-1:0]      voxel_value,
	input  logic                              include_flag,
	input  vap_pkg::cmd_t                     cmd,
	output vap_pkg::sts_t                     sts,
	output logic signed [vap_pkg::RES_W-1:0]  result_value,
	output logic [vap_pkg::POS_W-1:0]         out_pos_a,
	output logic [vap_pkg::POS_W-1:0]         out_pos_b,
	output logic                              volume_done
);
	localparam int SZW    = vap_pkg::SZW;
	localparam int RES_W  = vap_pkg::RES_W;
	localparam int MAXLEN = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
		: ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);
	localparam int TOT_W  = VALUE_BITS + $clog2(MAXLEN);
	localparam int RW     = (TOT_W > RES_W) ? TOT_W : RES_W;
	localparam int PXW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
	localparam int PYW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
	localparam int PZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int D_XY   = MAX_X * MAX_Y;
	localparam int D_XZ   = MAX_X * MAX_Z;
	localparam int D_YZ   = MAX_Y * MAX_Z;
	localparam int ACC_DEPTH = (D_XY > D_XZ) ? ((D_XY > D_YZ) ? D_XY : D_YZ)
		: ((D_XZ > D_YZ) ? D_XZ : D_YZ);
	localparam int AW     = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int MW     = 2 * VALUE_BITS + TOT_W;

	localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic signed [RW-1:0] LIM_HI = RW'((64'sd1 <<< (RES_W - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] LIM_LO = -LIM_HI - RW'(1);

	function automatic logic [SZW-1:0] clamp_size(input logic [SZW-1:0] s, input int mx);
		logic [SZW-1:0] r;
		r = s;
		if (s == '0) begin
			r = SZW'(1);
		end else if (32'(s) > 32'(mx)) begin
			r = SZW'(mx);
		end
		return r;
	endfunction

	function automatic logic signed [RES_W-1:0] sat(input logic signed [RW-1:0] r);
		logic signed [RW-1:0] t;
		t = r;
		if (r > LIM_HI) begin
			t = LIM_HI;
		end else if (r < LIM_LO) begin
			t = LIM_LO;
		end
		return RES_W'(t);
	endfunction

	// configuration
	logic [1:0]     axis_q;
	logic [1:0]     op_q;
	logic [SZW-1:0] sx_q, sy_q, sz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= vap_pkg::AXIS_Z;
			op_q   <= vap_pkg::OP_MAX;
			sx_q   <= SZW'(64);
			sy_q   <= SZW'(64);
			sz_q   <= SZW'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				vap_pkg::REG_AXIS:   axis_q <= cfg_data[1:0];
				vap_pkg::REG_OP:     op_q   <= cfg_data[1:0];
				vap_pkg::REG_SIZE_X: sx_q   <= cfg_data;
				vap_pkg::REG_SIZE_Y: sy_q   <= cfg_data;
				vap_pkg::REG_SIZE_Z: sz_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// position and addressing
	logic [PXW-1:0] pos_x_q;
	logic [PYW-1:0] pos_y_q;
	logic [PZW-1:0] pos_z_q;
	logic [SZW-1:0] nx, ny, nz, len;
	logic           last_x, last_y, last_z;
	logic [31:0]    p32, a32, b32, idx32;
	logic           act;

	assign nx = clamp_size(sx_q, MAX_X);
	assign ny = clamp_size(sy_q, MAX_Y);
	assign nz = clamp_size(sz_q, MAX_Z);
	assign last_x = 32'(pos_x_q) >= 32'(nx) - 32'd1;
	assign last_y = 32'(pos_y_q) >= 32'(ny) - 32'd1;
	assign last_z = 32'(pos_z_q) >= 32'(nz) - 32'd1;

	always_comb begin
		act = 1'b1;
		case (axis_q)
			vap_pkg::AXIS_X: begin
				a32 = 32'(pos_y_q); b32 = 32'(pos_z_q); p32 = 32'(pos_x_q); len = nx;
				idx32 = a32 + b32 * 32'(MAX_Y);
			end
			vap_pkg::AXIS_Y: begin
				a32 = 32'(pos_x_q); b32 = 32'(pos_z_q); p32 = 32'(pos_y_q); len = ny;
				idx32 = a32 + b32 * 32'(MAX_X);
			end
			default: begin
				a32 = 32'(pos_x_q); b32 = 32'(pos_y_q); p32 = 32'(pos_z_q); len = nz;
				idx32 = a32 + b32 * 32'(MAX_X);
				act = (axis_q == vap_pkg::AXIS_Z) && (nz != SZW'(1));
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (cmd.upd) begin
			if (!last_x) begin
				pos_x_q <= pos_x_q + PXW'(1);
			end else begin
				pos_x_q <= '0;
				if (!last_y) begin
					pos_y_q <= pos_y_q + PYW'(1);
				end else begin
					pos_y_q <= '0;
					pos_z_q <= last_z ? '0 : pos_z_q + PZW'(1);
				end
			end
		end
	end

	// item latched at accept
	logic signed [VALUE_BITS-1:0] v_q;
	logic                         inc_q, first_q, last_q, act_q, done_q;
	logic [AW-1:0]                idx_q;
	logic [SZW-1:0]               len_q;
	logic [vap_pkg::POS_W-1:0]    a_q, b_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q     <= voxel_value;
			inc_q   <= include_flag;
			idx_q   <= idx32[AW-1:0];
			first_q <= p32 == 32'd0;
			last_q  <= p32 >= 32'(len) - 32'd1;
			act_q   <= act;
			len_q   <= len;
			a_q     <= vap_pkg::POS_W'(a32);
			b_q     <= vap_pkg::POS_W'(b32);
			done_q  <= last_x && last_y && last_z;
		end
	end

	// accumulator memory: {min, max, total}
	logic [MW-1:0] mem [ACC_DEPTH];
	logic [MW-1:0] rd_q;
	logic signed [VALUE_BITS-1:0] min_b, max_b, min_n, max_n;
	logic signed [TOT_W-1:0]      tot_b, tot_n;

	assign min_b = first_q ? VMAX : $signed(rd_q[MW-1 -: VALUE_BITS]);
	assign max_b = first_q ? VMIN : $signed(rd_q[TOT_W +: VALUE_BITS]);
	assign tot_b = first_q ? '0 : $signed(rd_q[TOT_W-1:0]);
	assign min_n = (inc_q && v_q < min_b) ? v_q : min_b;
	assign max_n = (inc_q && v_q > max_b) ? v_q : max_b;
	assign tot_n = inc_q ? tot_b + TOT_W'(v_q) : tot_b;

	always_ff @(posedge clk) begin
		if (cmd.upd && act_q) begin
			mem[idx_q] <= {min_n, max_n, tot_n};
		end
		if (cmd.accept) begin
			rd_q <= mem[idx32[AW-1:0]];
		end
	end

	// result selection and averaging
	logic signed [RW-1:0]    pick;
	logic signed [RW-1:0]    res_q;
	logic signed [TOT_W-1:0] quot;
	logic                    div_busy;

	always_comb begin
		case (op_q)
			vap_pkg::OP_MAX: pick = RW'(max_n);
			vap_pkg::OP_MIN: pick = RW'(min_n);
			default:         pick = RW'(tot_n);
		endcase
	end

	vap_div #(.TOT_W(TOT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (tot_n),
		.divisor  (len_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			res_q <= pick;
		end else if (cmd.div_take) begin
			res_q <= RW'(quot);
		end
		if (cmd.load_pick || cmd.load_res) begin
			result_value <= cmd.load_pick ? sat(pick) : sat(res_q);
			out_pos_a    <= a_q;
			out_pos_b    <= b_q;
			volume_done  <= done_q;
		end
	end

	assign sts.active   = act_q;
	assign sts.last     = last_q;
	assign sts.avg      = op_q == vap_pkg::OP_AVG;
	assign sts.div_busy = div_busy;
endmodule

// File: sv/volume_axis_projection_top.sv
// Top level of the axis projection block: channels, sequencer and datapath.
// Depends on vap_pkg, vap_ifs, vap_ctrl, vap_dp (and vap_div below it).
//
//  channel  | direction | payload                                         | transaction
//  ---------+-----------+-------------------------------------------------+-------------------
//  voxel    | in        | voxel_value, include_flag                       | valid && ready
//  result   | out       | result_value, out_pos_a, out_pos_b, volume_done | valid && ready
//  cfg      | in        | index, data                                     | valid && ready (=1)
//
// A voxel is handled in two steps: accept plus accumulator read, then write-back;
// the next voxel is taken only after that read-modify-write of its accumulator entry.
// An average result also passes through the one-bit-per-cycle divider, which yields a TOT_W-bit
// quotient (TOT_W = VALUE_BITS + log2 of the largest MAX, 38 by default).
// Reset clears position and sequencer and sets configuration to its defaults; accumulators need no clear,
// the first voxel along the axis initializes its entry.
// A stalled result holds in the output register; the next voxel is still taken
// and waits only if it produces a result of its own.
module volume_axis_projection_top #(
	parameter int MAX_X      = 64,
	parameter int MAX_Y      = 64,
	parameter int MAX_Z      = 64,
	parameter int VALUE_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	vap_in_if.sink     voxel,
	vap_out_if.source  result,
	vap_cfg_if.sink    cfg
);
	vap_pkg::cmd_t cmd;
	vap_pkg::sts_t sts;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	// sequencer: owns the voxel and result handshakes and the result valid flag
	vap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (voxel.valid),
		.in_ready  (voxel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: positions, accumulators, divider and the output payload register
	vap_dp #(
		.MAX_X      (MAX_X),
		.MAX_Y      (MAX_Y),
		.MAX_Z      (MAX_Z),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.voxel_value  (voxel.voxel_value),
		.include_flag (voxel.include_flag),
		.cmd          (cmd),
		.sts          (sts),
		.result_value (result.result_value),
		.out_pos_a    (result.out_pos_a),
		.out_pos_b    (result.out_pos_b),
		.volume_done  (result.volume_done)
	);
endmodule
